>>> hw/rtl/sponge_permutation_1536_unit_assert.svh
// Assertion macros shared by the bash-f unit.
`ifndef SPONGE_PERMUTATION_1536_UNIT_ASSERT_SVH
`define SPONGE_PERMUTATION_1536_UNIT_ASSERT_SVH

// Implication checked at every rising edge outside reset.
`define SPU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define SPU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/spu_pkg.sv
package spu_pkg;

  localparam int unsigned WORDS = 24;
  localparam int unsigned NUM_ROUNDS_DEF = 24;
  localparam int unsigned SLOT_W = 5;
  localparam int unsigned LAST_SLOT = 23;

  typedef struct packed {
    logic [63:0] in_word;
    logic        in_last;
  } in_t;

  typedef struct packed {
    logic [63:0] out_word;
    logic        out_last;
  } out_t;

  // One classified word: destination slot and the last flag.
  typedef struct packed {
    logic [63:0]       word;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } cmd_t;

  // Head of the queue between front and back.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } qhead_t;

  typedef logic [WORDS-1:0][63:0] state_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_RUN,
    ST_OUT
  } back_state_e;

  localparam logic [63:0] RC [24] = '{
    64'h3BF5080AC8BA94B1, 64'hC1D1659C1BBD92F6, 64'h60E8B2CE0DDEC97B,
    64'hEC5FB8FE790FBC13, 64'hAA043DE6436706A7, 64'h8929FF6A5E535BFD,
    64'h98BF1E2C50C97550, 64'h4C5F8F162864BAA8, 64'h262FC78B14325D54,
    64'h1317E3C58A192EAA, 64'h098BF1E2C50C9755, 64'hD8EE19681D669304,
    64'h6C770CB40EB34982, 64'h363B865A0759A4C1, 64'hC73622B47C4C0ACE,
    64'h639B115A3E260567, 64'hEDE6693460F3DA1D, 64'hAAD8D5034F9935A0,
    64'h556C6A81A7CC9AD0, 64'h2AB63540D3E64D68, 64'h155B1AA069F326B4,
    64'h0AAD8D5034F9935A, 64'h0556C6A81A7CC9AD, 64'hDE8082CD72DEBC78
  };

  localparam int unsigned ROT_M1 [8] = '{8, 56, 8, 56, 8, 56, 8, 56};
  localparam int unsigned ROT_N1 [8] = '{53, 51, 37, 3, 21, 19, 5, 35};
  localparam int unsigned ROT_M2 [8] = '{14, 34, 46, 2, 14, 34, 46, 2};
  localparam int unsigned ROT_N2 [8] = '{1, 7, 49, 23, 33, 39, 17, 55};

  localparam int unsigned WORD_PERM [24] = '{
    15, 10, 9, 12, 11, 14, 13, 8,
    17, 16, 19, 18, 21, 20, 23, 22,
    6, 3, 0, 5, 2, 7, 4, 1
  };

  function automatic logic [63:0] rotl(logic [63:0] x, int unsigned r);
    int unsigned rr;
    rr = r & 63;
    if (rr == 0) begin
      return x;
    end
    return (x << rr) | (x >> (64 - rr));
  endfunction

  // One bash-f round without the constant: bash-S on every column, then P.
  function automatic state_t round_f(state_t s);
    state_t m;
    state_t p;
    logic [63:0] a, b, c, t0, t1, s0, s1, s2;
    for (int j = 0; j < 8; j++) begin
      a  = s[j];
      b  = s[8+j];
      c  = s[16+j];
      t0 = rotl(a, ROT_M1[j]);
      s0 = a ^ b ^ c;
      t1 = b ^ rotl(s0, ROT_N1[j]);
      s1 = t0 ^ t1;
      s2 = c ^ rotl(c, ROT_M2[j]) ^ rotl(t1, ROT_N2[j]);
      m[j]    = s0 ^ ((~s2) | s1);
      m[8+j]  = s1 ^ (s0 | s2);
      m[16+j] = s2 ^ (s0 & s1);
    end
    for (int j = 0; j < 24; j++) begin
      p[j] = m[WORD_PERM[j]];
    end
    return p;
  endfunction

endpackage

>>> hw/rtl/sponge_permutation_1536_unit.sv
// Channel   | Handshake           | Payload
// ----------+---------------------+--------------------------------------
// input     | push / full         | in_i  : in_word (64), in_last (1)
// result    | empty / pop         | out_o : out_word (64), out_last (1)
//
// A block of 24 words enters one word per cycle while the front queue is not
// full, NUM_ROUNDS rounds follow (one full bash-f round per cycle), then 24
// words leave, one per pop. The round logic is a single unit and the state is
// a single 24-word register set.
// Reset clears the control state only; the state words are not cleared.
// The two-entry front queue can take up to two words while rounds or unloading run.

`include "sponge_permutation_1536_unit_assert.svh"

module sponge_permutation_1536_unit #(
  parameter int unsigned NUM_ROUNDS = spu_pkg::NUM_ROUNDS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  spu_pkg::in_t  in_i,
  output logic          empty,
  input  logic          pop,
  output spu_pkg::out_t out_o
);

  // The front classifies each accepted word by its slot and queues it for the back.
  spu_pkg::qhead_t head;
  logic            deq;

  spu_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .full   (full),
    .in_i   (in_i),
    .deq_i  (deq),
    .head_o (head)
  );

  // The back loads slots, runs the rounds and unloads the result.
  spu_core #(
    .NUM_ROUNDS (NUM_ROUNDS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .deq_o  (deq),
    .empty  (empty),
    .pop    (pop),
    .out_o  (out_o)
  );

  // A result always starts with word 0, never with the last word.
  `SPU_ASSERT_IMP(a_first_not_last, $fell(empty), !out_o.out_last,
    "result began on the last word")
  // Taking the last word ends the result.
  `SPU_ASSERT_NEXT(a_last_ends, !empty && pop && out_o.out_last, empty,
    "result continued after the last word")
  // The back only dequeues what the front holds.
  `SPU_ASSERT_IMP(a_deq_valid, deq, head.valid, "dequeue from an empty queue")

endmodule

>>> hw/rtl/spu_front.sv
module spu_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  spu_pkg::in_t       in_i,
  input  logic               deq_i,
  output spu_pkg::qhead_t    head_o
);

  logic [spu_pkg::SLOT_W-1:0] cnt_q, cnt_d;
  spu_pkg::cmd_t              ent_q [2];
  logic                       wp_q, rp_q;
  logic [1:0]                 lvl_q, lvl_d;
  logic                       acc, enq;
  spu_pkg::cmd_t              cmd;

  assign full = (lvl_q == 2'd2);
  assign acc  = push && !full;

  // Words past slot 22 without the last flag are dropped here.
  always_comb begin
    cnt_d     = cnt_q;
    enq       = 1'b0;
    cmd.word  = in_i.in_word;
    cmd.last  = in_i.in_last;
    cmd.slot  = cnt_q;
    if (acc) begin
      if (in_i.in_last) begin
        cmd.slot = spu_pkg::SLOT_W'(spu_pkg::LAST_SLOT);
        cnt_d    = '0;
        enq      = 1'b1;
      end else if (cnt_q < spu_pkg::SLOT_W'(spu_pkg::LAST_SLOT)) begin
        cnt_d = cnt_q + 1'b1;
        enq   = 1'b1;
      end
    end
    lvl_d = lvl_q + {1'b0, enq} - {1'b0, deq_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      lvl_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      lvl_q <= lvl_d;
      if (enq) begin
        wp_q <= !wp_q;
      end
      if (deq_i) begin
        rp_q <= !rp_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      ent_q[wp_q] <= cmd;
    end
  end

  assign head_o.valid = (lvl_q != 2'd0);
  assign head_o.cmd   = ent_q[rp_q];

endmodule

>>> hw/rtl/spu_core.sv
module spu_core #(
  parameter int unsigned NUM_ROUNDS = spu_pkg::NUM_ROUNDS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  spu_pkg::qhead_t head_i,
  output logic            deq_o,
  output logic            empty,
  input  logic            pop,
  output spu_pkg::out_t   out_o
);

  spu_pkg::back_state_e       st_q, st_d;
  logic [4:0]                 rnd_q, rnd_d;
  logic [spu_pkg::SLOT_W-1:0] cnt_q, cnt_d;
  spu_pkg::state_t            s_q, s_d;

  always_comb begin
    st_d  = st_q;
    rnd_d = rnd_q;
    cnt_d = cnt_q;
    s_d   = s_q;
    deq_o = 1'b0;
    case (st_q)
      spu_pkg::ST_LOAD: begin
        if (head_i.valid) begin
          deq_o                  = 1'b1;
          s_d[head_i.cmd.slot]   = head_i.cmd.word;
          if (head_i.cmd.last) begin
            st_d = spu_pkg::ST_RUN;
          end
        end
      end
      spu_pkg::ST_RUN: begin
        s_d     = spu_pkg::round_f(s_q);
        s_d[23] = s_d[23] ^ spu_pkg::RC[rnd_q];
        if (rnd_q == 5'(NUM_ROUNDS - 1)) begin
          rnd_d = '0;
          st_d  = spu_pkg::ST_OUT;
        end else begin
          rnd_d = rnd_q + 1'b1;
        end
      end
      spu_pkg::ST_OUT: begin
        // Rotating the state one word per pop leaves it intact after word 23.
        if (pop) begin
          s_d = {s_q[0], s_q[23:1]};
          if (cnt_q == spu_pkg::SLOT_W'(spu_pkg::LAST_SLOT)) begin
            cnt_d = '0;
            st_d  = spu_pkg::ST_LOAD;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      default: begin
        st_d = spu_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= spu_pkg::ST_LOAD;
      rnd_q <= '0;
      cnt_q <= '0;
    end else begin
      st_q  <= st_d;
      rnd_q <= rnd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q <= s_d;
  end

  assign empty          = (st_q != spu_pkg::ST_OUT);
  assign out_o.out_word = s_q[0];
  assign out_o.out_last = (cnt_q == spu_pkg::SLOT_W'(spu_pkg::LAST_SLOT));

endmodule
